>>> hw/rtl/sce_pkg.sv
// ----------------------------------------------------------------------------
// sce_pkg: shared types and constants
// Item structs, opcodes and controller/datapath interface types for the
// subset convolution engine.
// ----------------------------------------------------------------------------
package sce_pkg;

    localparam int MAX_BITS     = 10;
    localparam int LOG_SIZE_W   = 4;
    localparam int IDX_W        = 10;
    localparam int VAL_W        = 64;
    localparam logic [LOG_SIZE_W-1:0] LOG_SIZE_RESET = 4'd10;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_RUN   = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    typedef struct packed {
        logic [1:0]              op;
        logic [IDX_W-1:0]        element_index;
        logic signed [VAL_W-1:0] f_value;
        logic signed [VAL_W-1:0] g_value;
    } t_in_item;

    typedef struct packed {
        logic signed [VAL_W-1:0] h_value;
        logic [IDX_W-1:0]        out_index;
    } t_out_item;

    // controller -> datapath
    typedef struct packed {
        logic load;   // reset the submask iterator
        logic step;   // issue one term and advance
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic iter_last;  // current term is the last of the run
        logic busy;       // terms still in the pipeline
    } t_dp_status;

endpackage

>>> hw/rtl/sce_ram.sv
// ----------------------------------------------------------------------------
// sce_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module sce_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/sce_ctrl.sv
// ----------------------------------------------------------------------------
// sce_ctrl: run sequencer
// Steps the datapath through every (mask, submask) term, then drains.
// ----------------------------------------------------------------------------
module sce_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  sce_pkg::t_dp_status i_status,
    output sce_pkg::t_dp_cmd    o_cmd,
    output logic                o_idle
);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_RUN   = 3'b010,
        S_DRAIN = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd.load = 1'b0;
        o_cmd.step = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_RUN;
                end
            end
            S_RUN: begin
                o_cmd.step = 1'b1;
                if (i_status.iter_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!i_status.busy) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_idle = (r_state == S_IDLE);

endmodule

>>> hw/rtl/sce_dp.sv
// ----------------------------------------------------------------------------
// sce_dp: convolution datapath
// Submask iterator, operand RAMs, split 64-bit multiplier, accumulator and
// result RAM. h[m] = sum over submasks s of m of f[s] * g[m ^ s].
// ----------------------------------------------------------------------------
module sce_dp #(
    parameter int MAX_BITS = sce_pkg::MAX_BITS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  sce_pkg::t_dp_cmd            i_cmd,
    output sce_pkg::t_dp_status         o_status,
    input  logic [MAX_BITS-1:0]         i_mask,
    // operand load
    input  logic                        i_wr_en,
    input  logic [MAX_BITS-1:0]         i_wr_addr,
    input  logic [sce_pkg::VAL_W-1:0]   i_f_data,
    input  logic [sce_pkg::VAL_W-1:0]   i_g_data,
    // result read
    input  logic                        i_rd_en,
    input  logic [MAX_BITS-1:0]         i_rd_addr,
    output logic [sce_pkg::VAL_W-1:0]   o_rd_data
);

    localparam int AW    = MAX_BITS;
    localparam int DEPTH = 1 << MAX_BITS;
    localparam int VW    = sce_pkg::VAL_W;
    localparam int HW    = VW / 2;

    typedef struct packed {
        logic          valid;
        logic          first;
        logic          last;
        logic [AW-1:0] m;
    } t_tag;

    logic [AW-1:0] r_m, r_s;
    t_tag          t0, r_t1, r_t2, r_t3;
    logic [VW-1:0] f_rdata, g_rdata;
    logic [VW-1:0] r_p0, r_prod, r_acc, n_acc;
    logic [HW-1:0] r_p1, r_p2;
    logic          s_zero;

    assign s_zero             = (r_s == '0);
    assign o_status.iter_last = s_zero && (r_m == i_mask);
    assign o_status.busy      = r_t1.valid || r_t2.valid || r_t3.valid;

    // submask walk: s = m, (s-1)&m, ..., 0; then next mask
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_m <= '0;
            r_s <= '0;
        end else if (i_cmd.step) begin
            if (s_zero) begin
                r_m <= r_m + AW'(1);
                r_s <= r_m + AW'(1);
            end else begin
                r_s <= (r_s - AW'(1)) & r_m;
            end
        end
    end

    assign t0.valid = i_cmd.step;
    assign t0.first = (r_s == r_m);
    assign t0.last  = s_zero;
    assign t0.m     = r_m;

    sce_ram #(.WIDTH(VW), .DEPTH(DEPTH)) u_f_ram (
        .i_clk  (i_clk),
        .i_we   (i_wr_en),
        .i_waddr(i_wr_addr),
        .i_wdata(i_f_data),
        .i_re   (i_cmd.step),
        .i_raddr(r_s),
        .o_rdata(f_rdata)
    );

    sce_ram #(.WIDTH(VW), .DEPTH(DEPTH)) u_g_ram (
        .i_clk  (i_clk),
        .i_we   (i_wr_en),
        .i_waddr(i_wr_addr),
        .i_wdata(i_g_data),
        .i_re   (i_cmd.step),
        .i_raddr(r_m ^ r_s),
        .o_rdata(g_rdata)
    );

    // low 64 bits of the product from three 32x32 partials
    always_ff @(posedge i_clk) begin
        r_p0   <= VW'(f_rdata[HW-1:0]) * VW'(g_rdata[HW-1:0]);
        r_p1   <= HW'(f_rdata[HW-1:0] * g_rdata[VW-1:HW]);
        r_p2   <= HW'(f_rdata[VW-1:HW] * g_rdata[HW-1:0]);
        r_prod <= r_p0 + {r_p1 + r_p2, {HW{1'b0}}};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t1.valid <= 1'b0;
            r_t2.valid <= 1'b0;
            r_t3.valid <= 1'b0;
        end else begin
            r_t1.valid <= t0.valid;
            r_t2.valid <= r_t1.valid;
            r_t3.valid <= r_t2.valid;
        end
        r_t1.first <= t0.first;
        r_t1.last  <= t0.last;
        r_t1.m     <= t0.m;
        r_t2.first <= r_t1.first;
        r_t2.last  <= r_t1.last;
        r_t2.m     <= r_t1.m;
        r_t3.first <= r_t2.first;
        r_t3.last  <= r_t2.last;
        r_t3.m     <= r_t2.m;
    end

    assign n_acc = r_t3.first ? r_prod : r_acc + r_prod;

    always_ff @(posedge i_clk) begin
        if (r_t3.valid) begin
            r_acc <= n_acc;
        end
    end

    sce_ram #(.WIDTH(VW), .DEPTH(DEPTH)) u_h_ram (
        .i_clk  (i_clk),
        .i_we   (r_t3.valid && r_t3.last),
        .i_waddr(r_t3.m),
        .i_wdata(n_acc),
        .i_re   (i_rd_en),
        .i_raddr(i_rd_addr),
        .o_rdata(o_rd_data)
    );

endmodule

>>> hw/rtl/subset_convolution_engine.sv
// ----------------------------------------------------------------------------
// subset_convolution_engine: subset convolution over 2^n masks
// Item-driven engine: load f/g, run, read back h.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (i_in_valid/o_in_ready, i_in_item) carries one item per
//    accept. op WRITE stores f and g at element_index (ignored when the index
//    is >= 2^n). op RUN computes h over all masks. op READ returns one result
//    item with h at the mask, or 0 when the mask is >= 2^n. Other ops do nothing.
//  - Output channel (o_out_valid/i_out_ready, o_out_item) carries read results.
//  - i_cfg_we/i_cfg_wdata write log_size (n); values above MAX_BITS act as
//    MAX_BITS. Write it only while the engine is idle.
//  - Writes and reads take one item per cycle while o_in_ready is high. A read
//    result passes through the h RAM read, then the output register.
//  - A run walks every (mask, submask) pair, one multiply-accumulate per
//    cycle through the f/g RAM read ports; no item is accepted until the
//    run has drained.
//  - A stalled receiver holds the output register; one further read may sit
//    in the RAM read stage, after which o_in_ready drops.
//  - Reset (synchronous, active low) sets log_size to 10 and idles the
//    engine. RAM contents are not cleared; read only masks that a run wrote.
// ----------------------------------------------------------------------------
module subset_convolution_engine #(
    parameter int MAX_BITS = sce_pkg::MAX_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  sce_pkg::t_in_item                   i_in_item,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output sce_pkg::t_out_item                  o_out_item,
    input  logic                                i_cfg_we,
    input  logic [sce_pkg::LOG_SIZE_W-1:0]      i_cfg_wdata
);

    localparam int AW = MAX_BITS;

    logic [sce_pkg::LOG_SIZE_W-1:0] r_log_size;
    logic [4:0]                     n_bits;     // active bit count
    logic [AW-1:0]                  mask;       // 2^n - 1
    logic                           in_range;
    logic                           accept;
    logic                           ctrl_idle;
    sce_pkg::t_dp_cmd               cmd;
    sce_pkg::t_dp_status            status;
    logic [sce_pkg::VAL_W-1:0]      rd_data;

    // read pipeline: RAM stage then output register
    logic                           r_pend;
    logic                           r_pend_zero;
    logic [sce_pkg::IDX_W-1:0]      r_pend_idx;
    logic                           r_out_valid;
    sce_pkg::t_out_item             r_out;
    logic                           move;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_log_size <= sce_pkg::LOG_SIZE_RESET;
        end else if (i_cfg_we) begin
            r_log_size <= i_cfg_wdata;
        end
    end

    assign n_bits   = (32'(r_log_size) > 32'(MAX_BITS)) ? 5'(MAX_BITS) : 5'(r_log_size);
    assign mask     = AW'((32'd1 << n_bits) - 32'd1);
    assign in_range = ((32'(i_in_item.element_index) >> n_bits) == 32'd0);

    assign move       = r_pend && (!r_out_valid || i_out_ready);
    assign o_in_ready = ctrl_idle && !(r_pend && !move);
    assign accept     = i_in_valid && o_in_ready;

    sce_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (accept && (i_in_item.op == sce_pkg::OP_RUN)),
        .i_status(status),
        .o_cmd   (cmd),
        .o_idle  (ctrl_idle)
    );

    sce_dp #(.MAX_BITS(MAX_BITS)) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .o_status (status),
        .i_mask   (mask),
        .i_wr_en  (accept && (i_in_item.op == sce_pkg::OP_WRITE) && in_range),
        .i_wr_addr(AW'(i_in_item.element_index)),
        .i_f_data (i_in_item.f_value),
        .i_g_data (i_in_item.g_value),
        .i_rd_en  (accept && (i_in_item.op == sce_pkg::OP_READ)),
        .i_rd_addr(AW'(i_in_item.element_index)),
        .o_rd_data(rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept && (i_in_item.op == sce_pkg::OP_READ)) begin
                r_pend <= 1'b1;
            end else if (move) begin
                r_pend <= 1'b0;
            end
            if (move) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (accept && (i_in_item.op == sce_pkg::OP_READ)) begin
            r_pend_zero <= !in_range;
            r_pend_idx  <= i_in_item.element_index;
        end
        if (move) begin
            r_out.h_value   <= r_pend_zero ? '0 : rd_data;
            r_out.out_index <= r_pend_idx;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule
